// ----- hdl/mm3bh_pkg.sv -----
// shared types, constants and command structs for the murmur3 bucket hasher
package mm3bh_pkg;

   localparam logic [31:0] MIX_C1  = 32'hCC9E2D51;
   localparam logic [31:0] MIX_C2  = 32'h1B873593;
   localparam logic [31:0] MIX_ADD = 32'hE6546B64;
   localparam logic [31:0] FIN_C1  = 32'h85EBCA6B;
   localparam logic [31:0] FIN_C2  = 32'hC2B2AE35;

   localparam int          HASH_W      = 32;
   localparam int          BCOUNT_W    = 17;
   localparam int          BIDX_W      = 16;
   localparam int          DIV_CNT_W   = $clog2(HASH_W);
   localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(4096);
   localparam logic [BCOUNT_W-1:0] BCOUNT_MAX   = BCOUNT_W'(65536);

   localparam logic [2:0] NB_ONE  = 3'd1;
   localparam logic [2:0] NB_TWO  = 3'd2;
   localparam logic [2:0] NB_THREE = 3'd3;
   localparam logic [2:0] NB_FOUR = 3'd4;
   localparam logic [2:0] NB_NONE = 3'd0;

   typedef struct packed {
      logic [31:0] key_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
      logic [15:0] key_length;
   } req_data_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [15:0] bucket_index;
   } rsp_data_type;

   typedef struct packed {
      logic accept;
      logic first;
      logic mix2;
      logic mix3;
      logic fin1;
      logic fin2;
      logic fin3;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic last_word;
      logic len_zero;
   } status_type;

endpackage

// ----- hdl/mm3bh_ctrl.sv -----
// controller state machine sequencing mix, finalise and bucket divide
module mm3bh_ctrl
   import mm3bh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MIX2 = 8'b0000_0010,
      ST_MIX3 = 8'b0000_0100,
      ST_FIN1 = 8'b0000_1000,
      ST_FIN2 = 8'b0001_0000,
      ST_FIN3 = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic                   key_open_ff, key_open_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      key_open_in  = key_open_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.first   = ~key_open_ff;
               key_open_in = 1'b1;
               state_in    = ST_MIX2;
            end
         end
         ST_MIX2: begin
            cmd.mix2 = 1'b1;
            state_in = ST_MIX3;
         end
         ST_MIX3: begin
            cmd.mix3 = 1'b1;
            if (status.last_word) begin
               key_open_in = 1'b0;
               state_in    = status.len_zero ? ST_IDLE : ST_FIN1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            cmd.fin3 = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(HASH_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         key_open_ff  <= key_open_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

// ----- hdl/mm3bh_dp.sv -----
// datapath: block and tail mix, finaliser, bit-serial modulo and result register
module mm3bh_dp
   import mm3bh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_data_type        req_data,
   input  logic                csr_write,
   input  logic [BCOUNT_W-1:0] csr_data,
   input  cmd_type             cmd,
   output status_type          status,
   output rsp_data_type        rsp_data
);

   logic [BCOUNT_W-1:0] bcount_ff, bcount_in;
   logic [31:0]         k_ff, k_in;
   logic [31:0]         run_ff, run_in;
   logic [15:0]         len_ff, len_in;
   logic                full_ff, full_in;
   logic                none_ff, none_in;
   logic                last_ff, last_in;
   logic [31:0]         f_ff, f_in;
   logic [31:0]         dvd_ff, dvd_in;
   logic [BCOUNT_W-1:0] rem_ff, rem_in;
   logic [BCOUNT_W-1:0] n_ff, n_in;
   rsp_data_type        rsp_ff, rsp_in;

   logic [2:0]          nb;
   logic [31:0]         masked;
   logic [31:0]         h_x;
   logic [31:0]         h_r;
   logic [31:0]         f_a;
   logic [31:0]         f_b;
   logic [BCOUNT_W:0]   trial;
   logic [BCOUNT_W:0]   n_ext;

   assign status.last_word = last_ff;
   assign status.len_zero  = (len_ff == 16'd0);
   assign rsp_data         = rsp_ff;

   always_comb begin
      nb = (req_data.valid_bytes > NB_FOUR) ? NB_FOUR : req_data.valid_bytes;
      case (nb)
         NB_ONE:   masked = {24'd0, req_data.key_word[7:0]};
         NB_TWO:   masked = {16'd0, req_data.key_word[15:0]};
         NB_THREE: masked = {8'd0, req_data.key_word[23:0]};
         default:  masked = req_data.key_word;
      endcase
      h_x   = run_ff ^ k_ff;
      h_r   = {h_x[18:0], h_x[31:19]};
      f_a   = run_ff ^ {16'd0, len_ff};
      f_a   = f_a ^ {16'd0, f_a[31:16]};
      f_b   = f_ff ^ {13'd0, f_ff[31:13]};
      n_ext = {1'b0, n_ff};
      trial = {rem_ff, dvd_ff[31]};
   end

   always_comb begin
      bcount_in = bcount_ff;
      k_in      = k_ff;
      run_in    = run_ff;
      len_in    = len_ff;
      full_in   = full_ff;
      none_in   = none_ff;
      last_in   = last_ff;
      f_in      = f_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      n_in      = n_ff;
      rsp_in    = rsp_ff;
      if (csr_write) begin
         bcount_in = csr_data;
      end
      if (cmd.accept) begin
         k_in    = masked * MIX_C1;
         full_in = (nb == NB_FOUR);
         none_in = (nb == NB_NONE);
         last_in = req_data.last_word;
         if (cmd.first) begin
            len_in = req_data.key_length;
            run_in = {16'd0, req_data.key_length};
         end
      end
      if (cmd.mix2) begin
         k_in = {k_ff[16:0], k_ff[31:17]} * MIX_C2;
      end
      if (cmd.mix3) begin
         if (full_ff) begin
            run_in = {h_r[29:0], 2'b00} + h_r + MIX_ADD;
         end else if (!none_ff) begin
            run_in = h_x;
         end
      end
      if (cmd.fin1) begin
         f_in = f_a * FIN_C1;
      end
      if (cmd.fin2) begin
         f_in = f_b * FIN_C2;
      end
      if (cmd.fin3) begin
         f_in   = f_ff ^ {16'd0, f_ff[31:16]};
         dvd_in = f_ff ^ {16'd0, f_ff[31:16]};
         rem_in = '0;
         if (bcount_ff == '0) begin
            n_in = BCOUNT_W'(1);
         end else if (bcount_ff > BCOUNT_MAX) begin
            n_in = BCOUNT_MAX;
         end else begin
            n_in = bcount_ff;
         end
      end
      if (cmd.div_step) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (trial >= n_ext) begin
            rem_in = BCOUNT_W'(trial - n_ext);
         end else begin
            rem_in = trial[BCOUNT_W-1:0];
         end
      end
      if (cmd.rsp_load) begin
         rsp_in.hash_value   = f_ff;
         rsp_in.bucket_index = rem_ff[BIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= BCOUNT_RESET;
         run_ff    <= '0;
         len_ff    <= '0;
      end else begin
         bcount_ff <= bcount_in;
         run_ff    <= run_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      full_ff <= full_in;
      none_ff <= none_in;
      last_ff <= last_in;
      f_ff    <= f_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- hdl/murmur3_bucket_hash.sv -----
// top level of the murmur3 x86_32 key hasher with bucket reduction
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_data   (req_data_type)
//   rsp       out        rsp_valid/rsp_ready    rsp_data   (rsp_data_type)
//   csr       in         csr_valid/csr_ready    csr_data   (bucket count, 17 bits)
//
// a word goes through accept with first multiply, second multiply and mix update
// the last word of a key of nonzero length adds the finaliser, the bit-serial
// modulo divider and the result register load; a zero-length key gives no result
// reset clears the controller and sets the bucket count to 4096
// a result waiting in the output register does not block further words; only a
// second finished key waits until the first result is taken
module murmur3_bucket_hash
   import mm3bh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_data_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_data_type        rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BCOUNT_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mm3bh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mm3bh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
